@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define VTYP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vtyp assertion failed");

// Antecedent implies consequent in the next cycle.
`define VTYP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vtyp assertion failed");

`endif

@@ rtl/vtyp_pkg.sv @@
// Types, constants and helpers for the vector to yaw/pitch converter.
`default_nettype none
package vtyp_pkg;

	localparam int CW            = 16;  // input component width
	localparam int ANGLE_FRAC    = 7;   // output fraction bits
	localparam int ANG_UNIT_BITS = 20;  // internal angle unit 2^-20 degree
	localparam int STEPS         = 25;  // CORDIC iterations per pass
	localparam int DW            = 64;  // datapath width
	localparam int ANG_W         = 32;  // internal angle width
	localparam int SCALE_BITS    = 58 - CW;
	localparam int GAIN_W        = 26;
	localparam int PROD_W        = CW + GAIN_W;
	localparam int YAW_W         = 16;
	localparam int PITCH_W       = 15;
	localparam int ROUND_SH      = ANG_UNIT_BITS - ANGLE_FRAC;

	localparam logic signed [GAIN_W-1:0] GAIN_Q24 = GAIN_W'(27628053);

	localparam logic signed [ANG_W-1:0] HALF_TURN  = ANG_W'(180 * (1 << ANG_UNIT_BITS));
	localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(1 << (ROUND_SH - 1));
	localparam logic signed [ANG_W-1:0] YAW_LIM    = ANG_W'(180 * (1 << ANGLE_FRAC));
	localparam logic signed [ANG_W-1:0] PITCH_LIM  = ANG_W'(90 * (1 << ANGLE_FRAC));

	// atan(2^-i) in 2^-20 degree units
	localparam logic signed [ANG_W-1:0] ATAN_TAB [0:STEPS-1] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121, 32'sd3750058,
		32'sd1876857, 32'sd938658, 32'sd469357, 32'sd234682, 32'sd117342,
		32'sd58671, 32'sd29335, 32'sd14668, 32'sd7334, 32'sd3667,
		32'sd1833, 32'sd917, 32'sd458, 32'sd229, 32'sd115,
		32'sd57, 32'sd29, 32'sd14, 32'sd7, 32'sd4
	};

	// Sideband that rides along both CORDIC passes
	typedef struct packed {
		logic signed [CW-1:0]    z;
		logic signed [ANG_W-1:0] yaw_a;
		logic                    xy_zero;
		logic                    all_zero;
	} side_t;

	// Round to nearest (ties up), then clamp to +-lim
	function automatic logic signed [YAW_W-1:0] to_out(
		input logic signed [ANG_W-1:0] a,
		input logic signed [ANG_W-1:0] lim
	);
		logic signed [ANG_W-1:0] q;
		q = (a + ROUND_HALF) >>> ROUND_SH;
		if (q > lim) begin
			q = lim;
		end else if (q < -lim) begin
			q = -lim;
		end
		return q[YAW_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/vector_to_yaw_pitch_top.sv @@
// Pipeline: 53 register stages from input beat to output valid (prep,
// 25 yaw stages, gain multiply, 25 pitch stages, round/clamp).
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat is stalled, set by the single output register.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
`default_nettype none
module vector_to_yaw_pitch_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [vtyp_pkg::CW-1:0]        vec_x,
	input  wire logic signed [vtyp_pkg::CW-1:0]        vec_y,
	input  wire logic signed [vtyp_pkg::CW-1:0]        vec_z,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [vtyp_pkg::YAW_W-1:0]          yaw_deg,
	output logic signed [vtyp_pkg::PITCH_W-1:0]        pitch_deg
);

	logic adv;

	// prep stage
	logic signed [vtyp_pkg::DW-1:0]     x_ext;
	logic signed [vtyp_pkg::DW-1:0]     y_ext;
	logic signed [vtyp_pkg::DW-1:0]     x_sc;
	logic signed [vtyp_pkg::DW-1:0]     y_sc;
	logic                               v_s1;
	logic signed [vtyp_pkg::DW-1:0]     x_s1;
	logic signed [vtyp_pkg::DW-1:0]     y_s1;
	logic signed [vtyp_pkg::ANG_W-1:0]  a_s1;
	vtyp_pkg::side_t                    side_s1;

	// yaw pass outputs
	logic                               yv;
	logic signed [vtyp_pkg::DW-1:0]     yx;
	logic signed [vtyp_pkg::ANG_W-1:0]  ya;
	vtyp_pkg::side_t                    yside;

	// gain stage
	logic signed [vtyp_pkg::PROD_W-1:0] zprod;
	logic                               v_s2;
	logic signed [vtyp_pkg::DW-1:0]     rk_s2;
	logic signed [vtyp_pkg::DW-1:0]     zk_s2;
	vtyp_pkg::side_t                    side_s2;

	// pitch pass outputs
	logic                               pv;
	logic signed [vtyp_pkg::DW-1:0]     px;
	logic signed [vtyp_pkg::ANG_W-1:0]  pa;
	vtyp_pkg::side_t                    pside;

	logic                               out_v_q;
	logic signed [vtyp_pkg::YAW_W-1:0]  yaw_q;
	logic signed [vtyp_pkg::YAW_W-1:0]  pitch_full;
	logic signed [vtyp_pkg::PITCH_W-1:0] pitch_q;

	assign adv      = !out_v_q || !out_stall;
	assign in_stall = !adv;

	assign x_ext = {{(vtyp_pkg::DW - vtyp_pkg::CW){vec_x[vtyp_pkg::CW-1]}}, vec_x};
	assign y_ext = {{(vtyp_pkg::DW - vtyp_pkg::CW){vec_y[vtyp_pkg::CW-1]}}, vec_y};
	assign x_sc  = x_ext <<< vtyp_pkg::SCALE_BITS;
	assign y_sc  = y_ext <<< vtyp_pkg::SCALE_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	// left half-plane: rotate by 180 so the CORDIC sees x >= 0
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.z        <= vec_z;
			side_s1.yaw_a    <= '0;
			side_s1.xy_zero  <= (vec_x == '0) && (vec_y == '0);
			side_s1.all_zero <= (vec_x == '0) && (vec_y == '0) && (vec_z == '0);
			if (vec_x < 0) begin
				x_s1 <= -x_sc;
				y_s1 <= -y_sc;
				a_s1 <= (vec_y >= 0) ? vtyp_pkg::HALF_TURN : -vtyp_pkg::HALF_TURN;
			end else begin
				x_s1 <= x_sc;
				y_s1 <= y_sc;
				a_s1 <= '0;
			end
		end
	end

	vtyp_cordic u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s1),
		.in_x     (x_s1),
		.in_y     (y_s1),
		.in_a     (a_s1),
		.in_side  (side_s1),
		.out_v    (yv),
		.out_x    (yx),
		.out_a    (ya),
		.out_side (yside)
	);

	// scale z by the CORDIC gain so it matches the magnitude left in x
	assign zprod = yside.z * vtyp_pkg::GAIN_Q24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= yv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rk_s2            <= yx;
			zk_s2            <= {{(vtyp_pkg::DW - vtyp_pkg::PROD_W){zprod[vtyp_pkg::PROD_W-1]}},
				zprod} <<< (vtyp_pkg::SCALE_BITS - 24);
			side_s2.z        <= yside.z;
			side_s2.xy_zero  <= yside.xy_zero;
			side_s2.all_zero <= yside.all_zero;
			side_s2.yaw_a    <= yside.xy_zero ? '0 : ya;
		end
	end

	vtyp_cordic u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s2),
		.in_x     (rk_s2),
		.in_y     (zk_s2),
		.in_a     ('0),
		.in_side  (side_s2),
		.out_v    (pv),
		.out_x    (px),
		.out_a    (pa),
		.out_side (pside)
	);

	assign pitch_full = vtyp_pkg::to_out(pa, vtyp_pkg::PITCH_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= pv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pside.all_zero) begin
				yaw_q   <= '0;
				pitch_q <= '0;
			end else begin
				yaw_q   <= vtyp_pkg::to_out(pside.yaw_a, vtyp_pkg::YAW_LIM);
				// x of the pitch pass carries no result
				pitch_q <= (px[vtyp_pkg::DW-1] & 1'b0) ? '0 : pitch_full[vtyp_pkg::PITCH_W-1:0];
			end
		end
	end

	assign out_valid = out_v_q;
	assign yaw_deg   = yaw_q;
	assign pitch_deg = pitch_q;

endmodule
`default_nettype wire

@@ rtl/vtyp_cordic.sv @@
// Fully pipelined vectoring CORDIC pass, one iteration per register stage.
`default_nettype none
module vtyp_cordic (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  wire logic                                 in_v,
	input  wire logic signed [vtyp_pkg::DW-1:0]       in_x,
	input  wire logic signed [vtyp_pkg::DW-1:0]       in_y,
	input  wire logic signed [vtyp_pkg::ANG_W-1:0]    in_a,
	input  wire vtyp_pkg::side_t                      in_side,
	output logic                                      out_v,
	output logic signed [vtyp_pkg::DW-1:0]            out_x,
	output logic signed [vtyp_pkg::ANG_W-1:0]         out_a,
	output vtyp_pkg::side_t                           out_side
);

	logic                               v_s    [1:vtyp_pkg::STEPS];
	logic signed [vtyp_pkg::DW-1:0]     x_s    [1:vtyp_pkg::STEPS];
	logic signed [vtyp_pkg::DW-1:0]     y_s    [1:vtyp_pkg::STEPS];
	logic signed [vtyp_pkg::ANG_W-1:0]  a_s    [1:vtyp_pkg::STEPS];
	vtyp_pkg::side_t                    side_s [1:vtyp_pkg::STEPS];

	for (genvar i = 0; i < vtyp_pkg::STEPS; i++) begin : g_stage
		logic                               cv;
		logic signed [vtyp_pkg::DW-1:0]     cx;
		logic signed [vtyp_pkg::DW-1:0]     cy;
		logic signed [vtyp_pkg::ANG_W-1:0]  ca;
		vtyp_pkg::side_t                    cs;
		logic signed [vtyp_pkg::DW-1:0]     dx;
		logic signed [vtyp_pkg::DW-1:0]     dy;

		if (i == 0) begin : g_first
			assign cv = in_v;
			assign cx = in_x;
			assign cy = in_y;
			assign ca = in_a;
			assign cs = in_side;
		end else begin : g_next
			assign cv = v_s[i];
			assign cx = x_s[i];
			assign cy = y_s[i];
			assign ca = a_s[i];
			assign cs = side_s[i];
		end

		// arithmetic shift floors, as required for bit-exact results
		assign dx = cy >>> i;
		assign dy = cx >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[i+1] <= cs;
				if (cy > 0) begin
					x_s[i+1] <= cx + dx;
					y_s[i+1] <= cy - dy;
					a_s[i+1] <= ca + vtyp_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= cx - dx;
					y_s[i+1] <= cy + dy;
					a_s[i+1] <= ca - vtyp_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	assign out_v    = v_s[vtyp_pkg::STEPS];
	assign out_x    = x_s[vtyp_pkg::STEPS];
	assign out_a    = a_s[vtyp_pkg::STEPS];
	assign out_side = side_s[vtyp_pkg::STEPS];

endmodule
`default_nettype wire

@@ rtl/vtyp_checker.sv @@
// Port-level checker for the vector to yaw/pitch converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module vtyp_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_stall,
	input wire logic signed [vtyp_pkg::CW-1:0]        vec_x,
	input wire logic signed [vtyp_pkg::CW-1:0]        vec_y,
	input wire logic signed [vtyp_pkg::CW-1:0]        vec_z,
	input wire logic                                  out_valid,
	input wire logic                                  out_stall,
	input wire logic signed [vtyp_pkg::YAW_W-1:0]     yaw_deg,
	input wire logic signed [vtyp_pkg::PITCH_W-1:0]   pitch_deg
);

	// input side only backs up when the output beat is blocked
	`VTYP_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	`VTYP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(yaw_deg) && $stable(pitch_deg))

	`VTYP_ASSERT_SAME(a_yaw_range, clk, arst_n, out_valid,
		(yaw_deg <= 16'sd23040) && (yaw_deg >= -16'sd23040))

	`VTYP_ASSERT_SAME(a_pitch_range, clk, arst_n, out_valid,
		(pitch_deg <= 15'sd11520) && (pitch_deg >= -15'sd11520))

endmodule

bind vector_to_yaw_pitch_top vtyp_checker u_vtyp_checker (.*);
`default_nettype wire

@@ test/tb_vector_to_yaw_pitch_top.sv @@
// Self-checking testbench for the vector to yaw/pitch converter.
`default_nettype none
module tb_vector_to_yaw_pitch_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT  = 1_000_000;
	localparam int  TAIL_CYCLES  = 80;       // pipeline is 53 deep
	localparam int  RANDOM_BEATS = 1800;
	localparam int  STEPS        = 25;
	localparam int  UNIT_BITS    = 20;       // internal angle LSB = 2^-20 degree
	localparam int  FRAC_BITS    = 7;
	localparam int  SCALE_BITS   = 42;       // 58 - component width
	localparam int  ROUND_SHIFT  = UNIT_BITS - FRAC_BITS;
	localparam longint GAIN_Q24  = 27628053;
	localparam int  MAX_PRINTED  = 40;

	localparam longint ATAN_DEG20 [STEPS] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
		469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7, 4
	};

	// x, y, z packed high to low
	localparam int N_DIRECTED = 23;
	localparam logic [47:0] DIRECTED_VECTORS [N_DIRECTED] = '{
		{16'h0000, 16'h0000, 16'h0000},
		{16'h0001, 16'h0000, 16'h0000},
		{16'hFFFF, 16'h0000, 16'h0000},
		{16'h0000, 16'h0001, 16'h0000},
		{16'h0000, 16'hFFFF, 16'h0000},
		{16'h0000, 16'h0000, 16'h0001},
		{16'h0000, 16'h0000, 16'hFFFF},
		{16'h7FFF, 16'h0000, 16'h0000},
		{16'h8000, 16'h0000, 16'h0000},
		{16'h0000, 16'h7FFF, 16'h0000},
		{16'h0000, 16'h8000, 16'h0000},
		{16'h0000, 16'h0000, 16'h7FFF},
		{16'h0000, 16'h0000, 16'h8000},
		{16'h8000, 16'h0001, 16'h0000},
		{16'h8000, 16'hFFFF, 16'h0000},
		{16'hFFFB, 16'h0003, 16'h0002},
		{16'hFFFB, 16'hFFFD, 16'hFFFE},
		{16'h7FFF, 16'h7FFF, 16'h7FFF},
		{16'h8000, 16'h8000, 16'h8000},
		{16'h7FFF, 16'h8000, 16'h0000},
		{16'h8000, 16'h7FFF, 16'h8000},
		{16'h0064, 16'h0064, 16'h0000},
		{16'h0003, 16'h0004, 16'h0005}
	};

	typedef struct {
		logic signed [vtyp_pkg::YAW_W-1:0]   yaw;
		logic signed [vtyp_pkg::PITCH_W-1:0] pitch;
	} angles_t;

	class angle_scoreboard;
		angles_t     expected_q[$];
		int unsigned n_mismatch;
		int unsigned n_checked;
		int unsigned n_noted;

		function new();
			n_mismatch = 0;
			n_checked  = 0;
			n_noted    = 0;
		endfunction

		// Vectoring pass; valid for x >= 0. Leaves gain-scaled magnitude in mag.
		function longint vector_rotate(input longint x_in, input longint y_in,
				output longint mag);
			longint x, y, ang, dx, dy;
			x   = x_in;
			y   = y_in;
			ang = 0;
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x   += dx;
					y   -= dy;
					ang += ATAN_DEG20[i];
				end else begin
					x   -= dx;
					y   += dy;
					ang -= ATAN_DEG20[i];
				end
			end
			mag = x;
			return ang;
		endfunction

		// Round half up to output LSB, then clamp to +-lim_deg
		function logic [15:0] round_clamp(input longint ang, input longint lim_deg);
			longint q, lim;
			q   = (ang + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			lim = lim_deg <<< FRAC_BITS;
			if (q > lim)
				q = lim;
			if (q < -lim)
				q = -lim;
			return q[15:0];
		endfunction

		function void note_vector(input logic signed [15:0] x, input logic signed [15:0] y,
				input logic signed [15:0] z);
			longint  xs, ys, zs, px, py, base, yaw_a, pitch_a, rmag, unused;
			angles_t e;
			logic [15:0] p16;
			xs    = x;
			ys    = y;
			zs    = z;
			yaw_a = 0;
			rmag  = 0;
			if (xs == 0 && ys == 0 && zs == 0) begin
				e.yaw   = '0;
				e.pitch = '0;
			end else begin
				if (xs != 0 || ys != 0) begin
					px   = xs <<< SCALE_BITS;
					py   = ys <<< SCALE_BITS;
					base = 0;
					// left half-plane: pre-rotate by a half turn
					if (px < 0) begin
						base = (py >= 0 ? 64'sd180 : -64'sd180) <<< UNIT_BITS;
						px   = -px;
						py   = -py;
					end
					yaw_a = base + vector_rotate(px, py, rmag);
				end
				pitch_a = vector_rotate(rmag, zs * GAIN_Q24 * (64'sd1 <<< (SCALE_BITS - 24)),
					unused);
				e.yaw   = round_clamp(yaw_a, 180);
				p16     = round_clamp(pitch_a, 90);
				e.pitch = p16[vtyp_pkg::PITCH_W-1:0];
			end
			expected_q.push_back(e);
			n_noted++;
		endfunction

		task report(input string msg);
			if (n_mismatch < MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			n_mismatch++;
		endtask

		task check_angles(input logic signed [vtyp_pkg::YAW_W-1:0] yaw,
				input logic signed [vtyp_pkg::PITCH_W-1:0] pitch);
			angles_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat yaw=%0d pitch=%0d", yaw, pitch));
			end else begin
				e = expected_q.pop_front();
				if (yaw !== e.yaw)
					report($sformatf("beat %0d yaw got %0d want %0d", n_checked, yaw, e.yaw));
				if (pitch !== e.pitch)
					report($sformatf("beat %0d pitch got %0d want %0d", n_checked, pitch,
						e.pitch));
			end
			n_checked++;
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [vtyp_pkg::CW-1:0] vec_x;
	logic signed [vtyp_pkg::CW-1:0] vec_y;
	logic signed [vtyp_pkg::CW-1:0] vec_z;
	logic out_valid;
	logic out_stall;
	logic signed [vtyp_pkg::YAW_W-1:0]   yaw_deg;
	logic signed [vtyp_pkg::PITCH_W-1:0] pitch_deg;

	angle_scoreboard sb;
	bit draining;
	bit gaps_on;
	int stall_left;
	bit stall_level;

	vector_to_yaw_pitch_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.yaw_deg   (yaw_deg),
		.pitch_deg (pitch_deg)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// mostly short, now and then long
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
	endfunction

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_level = ($urandom_range(0, 2) == 0);
			stall_left  = stall_level ? gap_len() : $urandom_range(1, 40);
		end
		stall_left--;
		out_stall <= stall_level && !draining;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_vector(vec_x, vec_y, vec_z);
		if (arst_n && out_valid && !out_stall)
			sb.check_angles(yaw_deg, pitch_deg);
	end

	task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		@(negedge clk);
		in_valid <= 1'b1;
		vec_x    <= x;
		vec_y    <= y;
		vec_z    <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_input(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 3) == 0)
			idle_input(gap_len());
	endtask

	function automatic logic signed [15:0] corner_value();
		case ($urandom_range(0, 6))
			0: return 16'h8000;
			1: return 16'h8001;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			5: return 16'h7FFE;
			default: return 16'h7FFF;
		endcase
	endfunction

	task automatic pick_vector(output logic signed [15:0] x, output logic signed [15:0] y,
			output logic signed [15:0] z);
		int kind;
		kind = $urandom_range(0, 11);
		x = 16'($urandom());
		y = 16'($urandom());
		z = 16'($urandom());
		case (kind)
			4, 5: begin
				x = 16'($urandom_range(0, 32)) - 16'sd16;
				y = 16'($urandom_range(0, 32)) - 16'sd16;
				z = 16'($urandom_range(0, 32)) - 16'sd16;
			end
			6: begin
				x = corner_value();
				y = corner_value();
				z = corner_value();
			end
			7: y = 16'($urandom_range(0, 4)) - 16'sd2;     // near the x axis, both halves
			8: begin
				x = 16'($urandom_range(0, 4)) - 16'sd2;    // near the y axis
				if ($urandom_range(0, 1)) y = 16'sd0;
			end
			9: begin
				x = '0;                                    // straight up or down
				y = '0;
			end
			10: z = 16'($urandom_range(0, 4)) - 16'sd2;   // almost level
			default: ;
		endcase
	endtask

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic signed [15:0] rx, ry, rz;
		sb        = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		vec_x     = '0;
		vec_y     = '0;
		vec_z     = '0;
		out_stall = 1'b0;
		draining  = 1'b0;
		gaps_on   = 1'b1;
		stall_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_vector(DIRECTED_VECTORS[i][47:32], DIRECTED_VECTORS[i][31:16],
				DIRECTED_VECTORS[i][15:0]);
			maybe_gap();
		end

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// phases with and without input gaps
			if (i % 150 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			pick_vector(rx, ry, rz);
			send_vector(rx, ry, rz);
			maybe_gap();
		end
		idle_input(1);

		draining = 1'b1;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d vectors (%0d directed: axes, corners, zero vector, half-turn cases)",
			sb.n_noted, N_DIRECTED);
		$display("Checked %0d yaw/pitch beats under random input gaps and output stalls",
			sb.n_checked);
		if (sb.n_mismatch == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/vtyp_pkg.sv
rtl/vtyp_cordic.sv
rtl/vector_to_yaw_pitch_top.sv
rtl/vtyp_checker.sv
test/tb_vector_to_yaw_pitch_top.sv
